>>> hw/rtl/utf16_to_utf8_transcoder_assert.svh
// ----------------------------------------------------------------------------
// UTF-16 to UTF-8 transcoder assertion macros
// Clocked, reset-qualified concurrent assertion shorthands.
// ----------------------------------------------------------------------------
`ifndef UTF16_TO_UTF8_TRANSCODER_ASSERT_SVH
`define UTF16_TO_UTF8_TRANSCODER_ASSERT_SVH

// expression must hold at every clock edge out of reset
`define U2U8_ASSERT_ALWAYS(label, clk, rst_n, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
		else $error("u2u8 assertion failed");

// antecedent implies consequent in the same cycle
`define U2U8_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("u2u8 assertion failed");

`endif

>>> hw/rtl/u2u8_pkg.sv
// ----------------------------------------------------------------------------
// UTF-16 to UTF-8 transcoder package
// Shared widths, status codes and the job record passed front to back.
// ----------------------------------------------------------------------------
package u2u8_pkg;

	localparam int OFFSET_WIDTH_DEF = 32;
	localparam int ERR_OFF_W        = 32;
	localparam int QUEUE_DEPTH      = 2;

	localparam logic [1:0] STATUS_OK           = 2'd0;
	localparam logic [1:0] STATUS_UNPAIRED_HIGH = 2'd1;
	localparam logic [1:0] STATUS_UNPAIRED_LOW  = 2'd2;

	localparam logic [5:0] HIGH_TAG = 6'b110110;
	localparam logic [5:0] LOW_TAG  = 6'b110111;

	typedef struct packed {
		logic [3:0][7:0]      bytes;
		logic [1:0]           nm1;
		logic [1:0]           status;
		logic [ERR_OFF_W-1:0] offset;
		logic                 eot;
	} job_t;

endpackage

>>> hw/rtl/u2u8_front.sv
// ----------------------------------------------------------------------------
// UTF-16 to UTF-8 front end
// Accepts code units, tracks surrogate pairing and text state, builds jobs.
// ----------------------------------------------------------------------------
module u2u8_front #(
	parameter int OFFSET_WIDTH = u2u8_pkg::OFFSET_WIDTH_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            unit_valid,
	output logic            unit_stall,
	input  logic [15:0]     unit_word,
	input  logic            last_unit,
	input  logic            q_full,
	output logic            push,
	output u2u8_pkg::job_t  push_job
);
	import u2u8_pkg::*;

	typedef struct packed {
		logic [3:0][7:0] bytes;
		logic [1:0]      nm1;
	} enc_t;

	function automatic enc_t encode(input logic [20:0] s);
		enc_t e;
		e.bytes = '0;
		priority if (s <= 21'h7F) begin
			e.bytes[0] = s[7:0];
			e.nm1 = 2'd0;
		end else if (s <= 21'h7FF) begin
			e.bytes[0] = 8'hC0 | {3'b0, s[10:6]};
			e.bytes[1] = 8'h80 | {2'b0, s[5:0]};
			e.nm1 = 2'd1;
		end else if (s <= 21'hFFFF) begin
			e.bytes[0] = 8'hE0 | {4'b0, s[15:12]};
			e.bytes[1] = 8'h80 | {2'b0, s[11:6]};
			e.bytes[2] = 8'h80 | {2'b0, s[5:0]};
			e.nm1 = 2'd2;
		end else begin
			e.bytes[0] = 8'hF0 | {5'b0, s[20:18]};
			e.bytes[1] = 8'h80 | {2'b0, s[17:12]};
			e.bytes[2] = 8'h80 | {2'b0, s[11:6]};
			e.bytes[3] = 8'h80 | {2'b0, s[5:0]};
			e.nm1 = 2'd3;
		end
		return e;
	endfunction

	logic [9:0]              high_q;
	logic                    pend_q;
	logic                    disc_q;
	logic [OFFSET_WIDTH-1:0] cnt_q;

	logic        accept;
	logic        is_high;
	logic        is_low;
	logic        emit;
	logic [20:0] pair_s;
	logic [20:0] scalar;
	enc_t        enc;

	assign unit_stall = q_full;
	assign accept     = unit_valid && !unit_stall;
	assign is_high    = unit_word[15:10] == HIGH_TAG;
	assign is_low     = unit_word[15:10] == LOW_TAG;
	assign pair_s     = {1'b0, high_q, unit_word[9:0]} + 21'h10000;
	assign scalar     = pend_q ? pair_s : {5'b0, unit_word};
	assign enc        = encode(scalar);
	assign push       = accept && emit;

	always_comb begin
		emit              = 1'b0;
		push_job.bytes    = enc.bytes;
		push_job.nm1      = enc.nm1;
		push_job.status   = STATUS_OK;
		push_job.offset   = '0;
		push_job.eot      = last_unit;
		if (!disc_q) begin
			emit = 1'b1;
			if (pend_q) begin
				if (!is_low) begin
					push_job.status = STATUS_UNPAIRED_HIGH;
					push_job.offset = ERR_OFF_W'(cnt_q - OFFSET_WIDTH'(1));
				end
			end else if (is_high) begin
				emit = last_unit;
				push_job.status = STATUS_UNPAIRED_HIGH;
				push_job.offset = ERR_OFF_W'(cnt_q);
			end else if (is_low) begin
				push_job.status = STATUS_UNPAIRED_LOW;
				push_job.offset = ERR_OFF_W'(cnt_q);
			end
			if (push_job.status != STATUS_OK) begin
				push_job.bytes = '0;
				push_job.nm1   = 2'd0;
				push_job.eot   = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			high_q <= '0;
			pend_q <= 1'b0;
			disc_q <= 1'b0;
			cnt_q  <= '0;
		end else if (accept) begin
			if (last_unit) begin
				high_q <= '0;
				pend_q <= 1'b0;
				disc_q <= 1'b0;
				cnt_q  <= '0;
			end else begin
				cnt_q <= cnt_q + OFFSET_WIDTH'(1);
				if (!disc_q) begin
					if (pend_q) begin
						pend_q <= 1'b0;
						high_q <= '0;
						disc_q <= !is_low;
					end else if (is_high) begin
						pend_q <= 1'b1;
						high_q <= unit_word[9:0];
					end else if (is_low) begin
						disc_q <= 1'b1;
					end
				end
			end
		end
	end

endmodule

>>> hw/rtl/u2u8_queue.sv
// ----------------------------------------------------------------------------
// UTF-16 to UTF-8 job queue
// Short register queue decoupling the front end from the byte emitter.
// ----------------------------------------------------------------------------
`include "utf16_to_utf8_transcoder_assert.svh"

module u2u8_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  u2u8_pkg::job_t push_job,
	output logic           full,
	input  logic           pop,
	output logic           head_valid,
	output u2u8_pkg::job_t head_job
);
	import u2u8_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	job_t             mem [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_q;
	logic [PTR_W-1:0] rd_q;
	logic [CNT_W-1:0] count_q;

	assign full       = count_q == CNT_W'(QUEUE_DEPTH);
	assign head_valid = count_q != '0;
	assign head_job   = mem[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + CNT_W'(1);
				2'b01:   count_q <= count_q - CNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	`U2U8_ASSERT_IMPLIES(a_no_overflow, clk, arst_n, push, !full)
	`U2U8_ASSERT_IMPLIES(a_no_underflow, clk, arst_n, pop, head_valid)
	`U2U8_ASSERT_ALWAYS(a_count_range, clk, arst_n, count_q <= CNT_W'(QUEUE_DEPTH))

endmodule

>>> hw/rtl/u2u8_back.sv
// ----------------------------------------------------------------------------
// UTF-16 to UTF-8 back end
// Walks the head job one result per transfer into the output register.
// ----------------------------------------------------------------------------
module u2u8_back (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           head_valid,
	input  u2u8_pkg::job_t                 head_job,
	output logic                           pop,
	output logic                           result_valid,
	input  logic                           result_stall,
	output logic [7:0]                     out_byte,
	output logic [1:0]                     status,
	output logic [u2u8_pkg::ERR_OFF_W-1:0] error_offset,
	output logic                           last_of_run,
	output logic                           end_of_text
);
	import u2u8_pkg::*;

	logic [1:0]           idx_q;
	logic                 valid_q;
	logic [7:0]           byte_q;
	logic [1:0]           status_q;
	logic [ERR_OFF_W-1:0] offset_q;
	logic                 run_q;
	logic                 eot_q;

	logic load;
	logic at_end;

	assign load   = head_valid && (!valid_q || !result_stall);
	assign at_end = idx_q == head_job.nm1;
	assign pop    = load && at_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			valid_q <= 1'b0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				idx_q   <= at_end ? 2'd0 : idx_q + 2'd1;
			end else if (!result_stall) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			byte_q   <= head_job.bytes[idx_q];
			status_q <= head_job.status;
			offset_q <= head_job.offset;
			run_q    <= at_end;
			eot_q    <= at_end && head_job.eot;
		end
	end

	assign result_valid = valid_q;
	assign out_byte     = byte_q;
	assign status       = status_q;
	assign error_offset = offset_q;
	assign last_of_run  = run_q;
	assign end_of_text  = eot_q;

endmodule

>>> hw/rtl/utf16_to_utf8_transcoder.sv
// The first result of a unit is registered in the job queue, then in the output
// register.
// Throughput: one result per cycle out of the output register while result_stall
// is low; a unit yields 1 to 4 bytes by its UTF-8 length (3 for most BMP units),
// held high units and dropped units yield none. The byte-serial back end sets the rate.
// Reset: arst_n clears surrogate, offset and discard state, the queue and the
// output valid at once.
// ----------------------------------------------------------------------------
// UTF-16 to UTF-8 transcoder top level
// Front end, job queue and byte emitter.
// ----------------------------------------------------------------------------
module utf16_to_utf8_transcoder #(
	parameter int OFFSET_WIDTH = u2u8_pkg::OFFSET_WIDTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           unit_valid,
	output logic                           unit_stall,
	input  logic [15:0]                    unit_word,
	input  logic                           last_unit,
	output logic                           result_valid,
	input  logic                           result_stall,
	output logic [7:0]                     out_byte,
	output logic [1:0]                     status,
	output logic [u2u8_pkg::ERR_OFF_W-1:0] error_offset,
	output logic                           last_of_run,
	output logic                           end_of_text
);
	import u2u8_pkg::*;

	logic q_full;
	logic push;
	logic pop;
	logic head_valid;
	job_t push_job;
	job_t head_job;

	u2u8_front #(
		.OFFSET_WIDTH(OFFSET_WIDTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.unit_valid(unit_valid),
		.unit_stall(unit_stall),
		.unit_word (unit_word),
		.last_unit (last_unit),
		.q_full    (q_full),
		.push      (push),
		.push_job  (push_job)
	);

	u2u8_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_job  (push_job),
		.full      (q_full),
		.pop       (pop),
		.head_valid(head_valid),
		.head_job  (head_job)
	);

	u2u8_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head_valid  (head_valid),
		.head_job    (head_job),
		.pop         (pop),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.out_byte    (out_byte),
		.status      (status),
		.error_offset(error_offset),
		.last_of_run (last_of_run),
		.end_of_text (end_of_text)
	);

endmodule

>>> dv/tb_top.sv
// ----------------------------------------------------------------------------
// UTF-16 to UTF-8 transcoder testbench
// Sends UTF-16 texts into the transcoder and checks every result against a
// behavioral model kept in a scoreboard. The texts are directed corner cases
// first, then random mostly well-formed texts with some broken ones. The
// sender idles and the receiver stalls at random.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import u2u8_pkg::*;

	typedef struct packed {
		logic [7:0]           utf8_byte;
		logic [1:0]           status;
		logic [ERR_OFF_W-1:0] offset;
		logic                 run_end;
		logic                 text_end;
	} utf8_result_t;

	class utf8_scoreboard;
		utf8_result_t expected_q[$];
		logic [9:0]   held_high;
		bit           held_valid;
		logic [31:0]  unit_offset;
		bit           dropping;
		int           mismatches;
		int           bytes_checked;
		int           four_byte_seqs;
		int           high_errors;
		int           low_errors;
		int           texts_seen;

		function void clear_text();
			held_high   = '0;
			held_valid  = 1'b0;
			unit_offset = '0;
			dropping    = 1'b0;
		endfunction

		function void push_error(logic [1:0] code, logic [31:0] where, bit last);
			utf8_result_t r;
			r = '{utf8_byte: 8'h00, status: code, offset: where, run_end: 1'b1,
				text_end: 1'b1};
			expected_q = {expected_q, r};
			if (last) begin
				clear_text();
			end else begin
				held_valid = 1'b0;
				held_high  = '0;
				dropping   = 1'b1;
			end
		endfunction

		function void push_scalar(logic [20:0] s, bit last);
			logic [7:0]   b [4];
			int           n;
			utf8_result_t r;
			if (s <= 21'h7F) begin
				b[0] = s[7:0];
				n = 1;
			end else if (s <= 21'h7FF) begin
				b[0] = 8'hC0 | {3'b0, s[10:6]};
				b[1] = 8'h80 | {2'b0, s[5:0]};
				n = 2;
			end else if (s <= 21'hFFFF) begin
				b[0] = 8'hE0 | {4'b0, s[15:12]};
				b[1] = 8'h80 | {2'b0, s[11:6]};
				b[2] = 8'h80 | {2'b0, s[5:0]};
				n = 3;
			end else begin
				b[0] = 8'hF0 | {5'b0, s[20:18]};
				b[1] = 8'h80 | {2'b0, s[17:12]};
				b[2] = 8'h80 | {2'b0, s[11:6]};
				b[3] = 8'h80 | {2'b0, s[5:0]};
				n = 4;
			end
			for (int k = 0; k < n; k++) begin
				r = '{utf8_byte: b[k], status: STATUS_OK, offset: '0,
					run_end: (k == n - 1), text_end: (last && k == n - 1)};
				expected_q = {expected_q, r};
			end
		endfunction

		// one accepted code unit
		function void note_unit(logic [15:0] cu, bit last);
			logic [31:0] here;
			bit          is_high;
			bit          is_low;
			here = unit_offset;
			unit_offset = unit_offset + 32'd1;
			is_high = (cu[15:10] == HIGH_TAG);
			is_low  = (cu[15:10] == LOW_TAG);
			if (last)
				texts_seen++;
			if (dropping) begin
				if (last)
					clear_text();
				return;
			end
			if (held_valid) begin
				if (!is_low) begin
					push_error(STATUS_UNPAIRED_HIGH, here - 32'd1, last);
					return;
				end
				push_scalar(21'h10000 + {1'b0, held_high, cu[9:0]}, last);
				held_valid = 1'b0;
				held_high  = '0;
				if (last)
					clear_text();
				return;
			end
			if (is_high) begin
				if (last) begin
					push_error(STATUS_UNPAIRED_HIGH, here, 1'b1);
					return;
				end
				held_high  = cu[9:0];
				held_valid = 1'b1;
				return;
			end
			if (is_low) begin
				push_error(STATUS_UNPAIRED_LOW, here, last);
				return;
			end
			push_scalar({5'd0, cu}, last);
			if (last)
				clear_text();
		endfunction

		function void compare_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
			if (act_v !== exp_v) begin
				$display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_v, act_v);
				mismatches++;
			end
		endfunction

		function void check_result(utf8_result_t got);
			utf8_result_t exp_r;
			if (expected_q.size() == 0) begin
				$display("%0t: unexpected result, byte %0h status %0d offset %0h",
					$time, got.utf8_byte, got.status, got.offset);
				mismatches++;
				return;
			end
			exp_r = expected_q.pop_front();
			compare_field("out_byte", exp_r.utf8_byte, got.utf8_byte);
			compare_field("status", exp_r.status, got.status);
			compare_field("error_offset", exp_r.offset, got.offset);
			compare_field("last_of_run", exp_r.run_end, got.run_end);
			compare_field("end_of_text", exp_r.text_end, got.text_end);
			if (exp_r.status == STATUS_UNPAIRED_HIGH)
				high_errors++;
			else if (exp_r.status == STATUS_UNPAIRED_LOW)
				low_errors++;
			else begin
				bytes_checked++;
				if (exp_r.utf8_byte[7:3] == 5'b11110)
					four_byte_seqs++;
			end
		endfunction

		function int outstanding();
			return expected_q.size();
		endfunction
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 unit_valid;
	logic                 unit_stall;
	logic [15:0]          unit_word;
	logic                 last_unit;
	logic                 result_valid;
	logic                 result_stall;
	logic [7:0]           out_byte;
	logic [1:0]           status;
	logic [ERR_OFF_W-1:0] error_offset;
	logic                 last_of_run;
	logic                 end_of_text;

	utf8_scoreboard sb = new();
	logic [15:0]    text_q[$];
	int             units_sent;
	int             texts_sent;
	int             calm_units;
	int             stall_left;
	int             stall_calm;
	int             stall_roll;
	utf8_result_t   seen;

	utf16_to_utf8_transcoder i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.unit_valid   (unit_valid),
		.unit_stall   (unit_stall),
		.unit_word    (unit_word),
		.last_unit    (last_unit),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.out_byte     (out_byte),
		.status       (status),
		.error_offset (error_offset),
		.last_of_run  (last_of_run),
		.end_of_text  (end_of_text)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// receiver stall pattern: mostly short, a few long, calm stretches
	always @(posedge clk) begin
		if (stall_calm > 0) begin
			stall_calm--;
			result_stall <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			result_stall <= 1'b1;
		end else begin
			stall_roll = $urandom_range(0, 99);
			if (stall_roll < 5) begin
				stall_calm = $urandom_range(20, 80);
				result_stall <= 1'b0;
			end else if (stall_roll < 60) begin
				result_stall <= 1'b0;
			end else if (stall_roll < 95) begin
				stall_left = $urandom_range(0, 2);
				result_stall <= 1'b1;
			end else begin
				stall_left = $urandom_range(10, 40);
				result_stall <= 1'b1;
			end
		end
	end

	// values at the falling edge are the ones the next rising edge sees
	always @(negedge clk) begin
		if (arst_n === 1'b1 && result_valid === 1'b1 && result_stall === 1'b0) begin
			seen = '{utf8_byte: out_byte, status: status, offset: error_offset,
				run_end: last_of_run, text_end: end_of_text};
			sb.check_result(seen);
		end
	end

	function automatic int next_gap();
		int roll;
		if (calm_units > 0) begin
			calm_units--;
			return 0;
		end
		roll = $urandom_range(0, 99);
		if (roll < 4) begin
			calm_units = $urandom_range(15, 50);
			return 0;
		end
		if (roll < 65)
			return 0;
		if (roll < 95)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	task automatic send_unit(input logic [15:0] cu, input bit last);
		int gap;
		bit taken;
		gap = next_gap();
		if (gap > 0) begin
			unit_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		unit_valid <= 1'b1;
		unit_word  <= cu;
		last_unit  <= last;
		do begin
			@(negedge clk);
			taken = (unit_stall === 1'b0);
			@(posedge clk);
		end while (!taken);
		sb.note_unit(cu, last);
		units_sent++;
	endtask

	task automatic send_text();
		for (int i = 0; i < text_q.size(); i++)
			send_unit(text_q[i], i == text_q.size() - 1);
		texts_sent++;
	endtask

	task automatic send_random_text();
		int          len;
		int          kind;
		bit          noise;
		logic [15:0] cu;
		text_q.delete();
		len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 30) : $urandom_range(1, 8);
		noise = ($urandom_range(0, 9) == 0);
		while (text_q.size() < len) begin
			if (noise) begin
				text_q = {text_q, 16'($urandom_range(0, 16'hFFFF))};
			end else begin
				kind = $urandom_range(0, 99);
				if (kind < 25) begin
					text_q = {text_q, 16'($urandom_range(0, 16'h7F))};
				end else if (kind < 45) begin
					text_q = {text_q, 16'($urandom_range(16'h80, 16'h7FF))};
				end else if (kind < 70) begin
					do cu = 16'($urandom_range(16'h800, 16'hFFFF));
					while (cu[15:11] == HIGH_TAG[5:1]);
					text_q = {text_q, cu};
				end else if (kind < 95) begin
					text_q = {text_q, {HIGH_TAG, 10'($urandom_range(0, 1023))}};
					text_q = {text_q, {LOW_TAG, 10'($urandom_range(0, 1023))}};
				end else if (kind < 98) begin
					text_q = {text_q, {HIGH_TAG, 10'($urandom_range(0, 1023))}};
				end else begin
					text_q = {text_q, {LOW_TAG, 10'($urandom_range(0, 1023))}};
				end
			end
		end
		send_text();
	endtask

	task automatic drain_results();
		unit_valid <= 1'b0;
		do @(posedge clk);
		while (sb.outstanding() != 0);
	endtask

	initial begin
		int wait_cycles;
		arst_n       = 1'b0;
		unit_valid   = 1'b0;
		unit_word    = '0;
		last_unit    = 1'b0;
		result_stall = 1'b0;
		sb.clear_text();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// byte length boundaries
		text_q = '{16'h0000, 16'h007F, 16'h0080, 16'h07FF, 16'h0800, 16'hFFFF};
		send_text();
		// lowest and highest supplementary scalars, pair ends the text
		text_q = '{16'hD800, 16'hDC00, 16'hDBFF, 16'hDFFF};
		send_text();
		// high then non-low, rest of text dropped
		text_q = '{16'h0041, 16'hD834, 16'h0042, 16'h0043, 16'hDC00, 16'h0044};
		send_text();
		// high as last unit
		text_q = '{16'hDBFF};
		send_text();
		// low with no high held, mid text
		text_q = '{16'h0020, 16'hDC01, 16'h0030};
		send_text();
		// low alone as last unit
		text_q = '{16'hDFFF};
		send_text();
		// high then high as last unit
		text_q = '{16'hD801, 16'hD802};
		send_text();

		while (units_sent < 430) begin
			if (texts_sent % 25 == 12)
				drain_results();
			send_random_text();
		end
		unit_valid <= 1'b0;

		wait_cycles = 0;
		while (sb.outstanding() != 0 && wait_cycles < 50000) begin
			@(posedge clk);
			wait_cycles++;
		end
		repeat (10) @(posedge clk);
		if (sb.outstanding() != 0) begin
			$display("%0t: %0d expected results never arrived", $time, sb.outstanding());
			sb.mismatches++;
		end

		$display("Sent %0d code units in %0d texts; checked %0d UTF-8 bytes (%0d four-byte leads).",
			units_sent, sb.texts_seen, sb.bytes_checked, sb.four_byte_seqs);
		$display("Unpaired surrogate reports checked: %0d high, %0d low; %0d mismatches.",
			sb.high_errors, sb.low_errors, sb.mismatches);
		if (sb.mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("%0t: timeout", $time);
		$display("*** FAILED ***");
		$finish;
	end

endmodule
